// ===== sv/gn_pkg.sv =====
// Shared types, constants and helpers of the gradient noise block.
// Depends on nothing; the front, queue, back and top files import it.
package gn_pkg;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam int FRAC_W   = 10;
  localparam int CORNER_W = 7;
  localparam int COORD_W  = 16;
  localparam int GRAD_W   = 16;
  localparam int VALUE_W  = 18;
  localparam int REGION_W = 4;
  localparam int DIM_W    = 11;
  localparam int BAND_MAX = 16;

  localparam logic [VALUE_W-1:0] BAND_LIMIT [BAND_MAX] = '{
    18'd1311, 18'd1966, 18'd3277, 18'd4588, 18'd9830, 18'd12452, 18'd17695,
    18'd32768, 18'd36045, 18'd58982, 18'd65536, 18'd262143, 18'd262143,
    18'd262143, 18'd262143, 18'd262143
  };

  typedef struct packed {
    logic                 eval;
    logic                 wr_ok;
    logic [CORNER_W-1:0]  r0;
    logic [CORNER_W-1:0]  r1;
    logic [CORNER_W-1:0]  c0;
    logic [CORNER_W-1:0]  c1;
    logic [GRAD_W-1:0]    gx;
    logic [GRAD_W-1:0]    gy;
    logic [FRAC_W-1:0]    fx;
    logic [FRAC_W-1:0]    fy;
  } gn_cmd_t;

  // Reduce a small index modulo a grid dimension by shifted subtraction.
  function automatic logic [CORNER_W-1:0] mod_wrap(input logic [CORNER_W-1:0] v,
                                                   input logic [DIM_W-1:0] m);
    logic [17:0] acc;
    logic [17:0] sh;
    acc = {11'b0, v};
    for (int k = CORNER_W - 1; k >= 0; k--) begin
      sh = {7'b0, m} << k;
      if (acc >= sh) begin
        acc = acc - sh;
      end
    end
    return acc[CORNER_W-1:0];
  endfunction

endpackage

// ===== sv/gn_if.sv =====
// Channel interfaces of the gradient noise block: sample/load input and result.
// Depends on nothing.
interface gn_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  grid_row;
  logic [5:0]  grid_col;
  logic [15:0] grad_x;
  logic [15:0] grad_y;
  logic [15:0] sample_x;
  logic [15:0] sample_y;
  modport source (output valid, mode, grid_row, grid_col, grad_x, grad_y, sample_x,
                  sample_y, input ready);
  modport sink (input valid, mode, grid_row, grid_col, grad_x, grad_y, sample_x,
                sample_y, output ready);
endinterface

interface gn_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] noise_value;
  logic [17:0]        noise_magnitude;
  logic [3:0]         region_index;
  modport source (output valid, noise_value, noise_magnitude, region_index, input ready);
  modport sink (input valid, noise_value, noise_magnitude, region_index, output ready);
endinterface

// ===== sv/gn_front.sv =====
// Front end: accepts items, classifies load vs evaluate, forms wrapped corners.
// Depends on gn_pkg.
module gn_front
  import gn_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          mode,
  input  logic [5:0]    grid_row,
  input  logic [5:0]    grid_col,
  input  logic [15:0]   grad_x,
  input  logic [15:0]   grad_y,
  input  logic [15:0]   sample_x,
  input  logic [15:0]   sample_y,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output gn_cmd_t       cmd
);

  logic    valid_r;
  gn_cmd_t cmd_r;
  gn_cmd_t cmd_nxt;
  logic [CORNER_W-1:0] x0;
  logic [CORNER_W-1:0] y0;

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  assign x0 = {1'b0, sample_x[COORD_W-1:FRAC_W]};
  assign y0 = {1'b0, sample_y[COORD_W-1:FRAC_W]};

  always_comb begin
    cmd_nxt = '0;
    cmd_nxt.eval = (mode == MODE_EVAL);
    if (mode == MODE_LOAD) begin
      cmd_nxt.wr_ok = ({5'b0, grid_row} < DIM_W'(GRID_ROWS)) &&
                      ({5'b0, grid_col} < DIM_W'(GRID_COLS));
      cmd_nxt.r0 = {1'b0, grid_row};
      cmd_nxt.c0 = {1'b0, grid_col};
      cmd_nxt.gx = grad_x;
      cmd_nxt.gy = grad_y;
    end else begin
      cmd_nxt.c0 = mod_wrap(x0, DIM_W'(GRID_COLS));
      cmd_nxt.c1 = mod_wrap(x0 + 1'b1, DIM_W'(GRID_COLS));
      cmd_nxt.r0 = mod_wrap(y0, DIM_W'(GRID_ROWS));
      cmd_nxt.r1 = mod_wrap(y0 + 1'b1, DIM_W'(GRID_ROWS));
      cmd_nxt.fx = sample_x[FRAC_W-1:0];
      cmd_nxt.fy = sample_y[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== sv/gn_queue.sv =====
// Short command queue between the front and back ends.
// Depends on gn_pkg.
module gn_queue
  import gn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  gn_cmd_t push_cmd,
  output logic    pop_valid,
  input  logic    pop_ready,
  output gn_cmd_t pop_cmd
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  gn_cmd_t          slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/gn_back.sv =====
// Back end: gradient grid copies, dot products, blends, rounding and banding.
// Depends on gn_pkg.
module gn_back
  import gn_pkg::*;
#(
  parameter int GRID_ROWS    = 64,
  parameter int GRID_COLS    = 64,
  parameter int REGION_BANDS = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  gn_cmd_t                   cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] noise_value,
  output logic [VALUE_W-1:0]        noise_magnitude,
  output logic [REGION_W-1:0]       region_index
);

  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  // Four copies of the grid, one per corner, so every corner has its own read port.
  logic [31:0] mem [4][GRID_ROWS][GRID_COLS];

  logic adv;
  logic pop;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [31:0]       rd_r [4];
  logic [FRAC_W-1:0] fx1_r, fy1_r, fx2_r, fy2_r, fy3_r;
  logic signed [28:0] dot_r [4];
  logic signed [40:0] row_r [2];
  logic signed [53:0] v46_r;

  logic [CORNER_W-1:0] rsel [4];
  logic [CORNER_W-1:0] csel [4];

  logic signed [10:0] dx [4];
  logic signed [10:0] dy [4];
  logic signed [28:0] dot_nxt [4];
  logic signed [11:0] wx0, wx1, wy0, wy1;
  logic signed [40:0] row_nxt [2];
  logic signed [53:0] v46_nxt;
  logic signed [23:0] rnd;
  logic signed [VALUE_W-1:0] val_nxt;
  logic [VALUE_W-1:0] mag_nxt;
  logic [REGION_W-1:0] reg_nxt;

  // Hold the whole pipe while the output register is full and not taken.
  assign adv       = !v5_r || out_ready;
  assign cmd_ready = adv;
  assign pop       = cmd_valid && adv;

  assign rsel[0] = cmd.r0; assign csel[0] = cmd.c0;
  assign rsel[1] = cmd.r0; assign csel[1] = cmd.c1;
  assign rsel[2] = cmd.r1; assign csel[2] = cmd.c0;
  assign rsel[3] = cmd.r1; assign csel[3] = cmd.c1;

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int j = 0; j < 4; j++) begin
        if (!cmd.eval && cmd.wr_ok) begin
          mem[j][RW'(cmd.r0)][CW'(cmd.c0)] <= {cmd.gy, cmd.gx};
        end
        if (cmd.eval) begin
          rd_r[j] <= mem[j][RW'(rsel[j])][CW'(csel[j])];
        end
      end
    end
  end

  // Offsets: near corner is the fraction, far corner is fraction minus one.
  always_comb begin
    dx[0] = {1'b0, fx1_r}; dx[2] = {1'b0, fx1_r};
    dx[1] = {1'b1, fx1_r}; dx[3] = {1'b1, fx1_r};
    dy[0] = {1'b0, fy1_r}; dy[1] = {1'b0, fy1_r};
    dy[2] = {1'b1, fy1_r}; dy[3] = {1'b1, fy1_r};
    for (int j = 0; j < 4; j++) begin
      dot_nxt[j] = 29'(dx[j] * $signed({1'b0, rd_r[j][15:0]})) +
                   29'(dy[j] * $signed({1'b0, rd_r[j][31:16]}));
    end
  end

  always_comb begin
    wx1 = {2'b0, fx2_r};
    wx0 = 12'sd1024 - wx1;
    row_nxt[0] = 41'(wx0 * dot_r[0]) + 41'(wx1 * dot_r[1]);
    row_nxt[1] = 41'(wx0 * dot_r[2]) + 41'(wx1 * dot_r[3]);
  end

  always_comb begin
    wy1 = {2'b0, fy3_r};
    wy0 = 12'sd1024 - wy1;
    v46_nxt = 54'(wy0 * row_r[0]) + 54'(wy1 * row_r[1]);
  end

  always_comb begin
    rnd = 24'((v46_r + 54'sd536870912) >>> 30);
    if (rnd > 24'sd131071) begin
      val_nxt = 18'sd131071;
    end else if (rnd < -24'sd131072) begin
      val_nxt = -18'sd131072;
    end else begin
      val_nxt = rnd[VALUE_W-1:0];
    end
    mag_nxt = val_nxt[VALUE_W-1] ? VALUE_W'(-val_nxt) : VALUE_W'(val_nxt);
    reg_nxt = REGION_W'(REGION_BANDS);
    for (int i = BAND_MAX - 1; i >= 0; i--) begin
      if (i < REGION_BANDS && mag_nxt <= BAND_LIMIT[i]) begin
        reg_nxt = REGION_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pop && cmd.eval;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (adv) begin
      fx1_r <= cmd.fx;
      fy1_r <= cmd.fy;
      fx2_r <= fx1_r;
      fy2_r <= fy1_r;
      fy3_r <= fy2_r;
      for (int j = 0; j < 4; j++) begin
        dot_r[j] <= dot_nxt[j];
      end
      row_r[0] <= row_nxt[0];
      row_r[1] <= row_nxt[1];
      v46_r    <= v46_nxt;
      noise_value     <= val_nxt;
      noise_magnitude <= mag_nxt;
      region_index    <= reg_nxt;
    end
  end

  assign out_valid = v5_r;

endmodule

// ===== sv/gradient_noise_2d_top.sv =====
// Gradient noise top level. Path: front-end register and queue, then back-end
// stages (grid read, dot products, x blend, y blend, round/band).
// One item per cycle unless out_ch stalls; each corner reads its own grid copy.
// Loads give no result. Synchronous active-low reset clears all control state;
// the grid is not cleared and holds garbage until written.
module gradient_noise_2d_top
  import gn_pkg::*;
#(
  parameter int GRID_ROWS    = 64,
  parameter int GRID_COLS    = 64,
  parameter int REGION_BANDS = 11
) (
  input logic        clk,
  input logic        rst_n,
  gn_in_if.sink      in_ch,
  gn_out_if.source   out_ch
);

  logic    f_valid;
  logic    f_ready;
  gn_cmd_t f_cmd;
  logic    q_valid;
  logic    q_ready;
  gn_cmd_t q_cmd;

  // Front: accept a transfer, split the point into cells and fractions.
  gn_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .mode      (in_ch.mode),
    .grid_row  (in_ch.grid_row),
    .grid_col  (in_ch.grid_col),
    .grad_x    (in_ch.grad_x),
    .grad_y    (in_ch.grad_y),
    .sample_x  (in_ch.sample_x),
    .sample_y  (in_ch.sample_y),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Queue: decouple front from back so each side stalls on its own.
  gn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // Back: write grid or evaluate; results leave from its output register.
  gn_back #(
    .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS), .REGION_BANDS(REGION_BANDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd_ready       (q_ready),
    .cmd             (q_cmd),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .noise_value     (out_ch.noise_value),
    .noise_magnitude (out_ch.noise_magnitude),
    .region_index    (out_ch.region_index)
  );

endmodule

// ===== sv/gn_checker.sv =====
// Port-level checks of the gradient noise block, bound to the top level.
// Depends on gn_if and gradient_noise_2d_top.
module gn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] noise_value,
  input logic [17:0]        noise_magnitude,
  input logic [3:0]         region_index
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("stalled result changed");

  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> noise_magnitude ==
      (noise_value[17] ? 18'(-noise_value) : 18'(noise_value)))
    else $error("magnitude mismatch");

  a_band0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && noise_magnitude <= 18'd1311 |-> region_index == 4'd0)
    else $error("lowest band wrong");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind gradient_noise_2d_top gn_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .noise_value     (out_ch.noise_value),
  .noise_magnitude (out_ch.noise_magnitude),
  .region_index    (out_ch.region_index)
);
